[design/ndefp_pkg.sv]
package ndefp_pkg;

  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_LAST = {POS_BITS{1'b1}};

  localparam logic [7:0] FLAG_MB  = 8'h80;
  localparam logic [7:0] FLAG_ME  = 8'h40;
  localparam logic [7:0] FLAG_SR  = 8'h10;
  localparam logic [7:0] FLAG_IL  = 8'h08;
  localparam logic [7:0] MASK_TNF = 8'h07;

  localparam logic [7:0] REC_LIMIT_RESET = 8'd16;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_NO_RECORD = 2'd2;
  localparam logic [1:0] ST_BAD_PARAM = 2'd3;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int CFG_ADDR_BITS = 3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_REC_LIMIT = 3'd0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic                item_kind;
    logic [2:0]          tnf;
    logic [POS_BITS-1:0] type_offset;
    logic [7:0]          type_length;
    logic [POS_BITS-1:0] id_offset;
    logic [7:0]          id_length;
    logic [POS_BITS-1:0] payload_offset;
    logic [15:0]         payload_length;
    logic [7:0]          record_count;
    logic [1:0]          status;
    logic                last_of_run;
  } out_t;

endpackage

[design/ndefp_core.sv]
module ndefp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat_acc,
  input  ndefp_pkg::in_t     beat,
  input  logic [7:0]         rec_limit,
  output ndefp_pkg::out_t    res0,
  output ndefp_pkg::out_t    res1,
  output logic [1:0]         res_cnt
);

  localparam logic [3:0] PH_HDR   = 4'd0;
  localparam logic [3:0] PH_TLEN  = 4'd1;
  localparam logic [3:0] PH_PLEN  = 4'd2;
  localparam logic [3:0] PH_IDLEN = 4'd3;
  localparam logic [3:0] PH_TYPE  = 4'd4;
  localparam logic [3:0] PH_ID    = 4'd5;
  localparam logic [3:0] PH_PAY   = 4'd6;

  logic [3:0]                    phase_r, phase_nxt;
  logic [ndefp_pkg::POS_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]                    flags_r, flags_nxt;
  logic [1:0]                    lbi_r, lbi_nxt;
  logic [31:0]                   rem_r, rem_nxt;
  logic [7:0]                    tlen_r, tlen_nxt;
  logic [7:0]                    idlen_r, idlen_nxt;
  logic [ndefp_pkg::POS_BITS-1:0] fo0_r, fo0_nxt, fo1_r, fo1_nxt, fo2_r, fo2_nxt;
  logic [7:0]                    recs_r, recs_nxt;
  logic                          first_r, first_nxt;
  logic                          done_r, done_nxt;

  logic [ndefp_pkg::POS_BITS-1:0] next_pos;
  ndefp_pkg::out_t               res [2];
  ndefp_pkg::out_t               sum;
  logic [1:0]                    n;
  logic                          completed, go_bodies, go_id, go_pay;
  logic [1:0]                    eob_st;

  assign next_pos = pos_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    lbi_nxt   = lbi_r;
    rem_nxt   = rem_r;
    tlen_nxt  = tlen_r;
    idlen_nxt = idlen_r;
    fo0_nxt   = fo0_r;
    fo1_nxt   = fo1_r;
    fo2_nxt   = fo2_r;
    recs_nxt  = recs_r;
    first_nxt = first_r;
    done_nxt  = done_r;
    res[0]    = '0;
    res[1]    = '0;
    sum       = '0;
    n         = 2'd0;
    completed = 1'b0;
    go_bodies = 1'b0;
    go_id     = 1'b0;
    go_pay    = 1'b0;
    eob_st    = ndefp_pkg::ST_OK;
    sum.item_kind = ndefp_pkg::KIND_SUMMARY;

    if (beat_acc && !done_r) begin
      if (pos_r == ndefp_pkg::POS_LAST) begin
        sum.record_count = recs_r;
        sum.status       = ndefp_pkg::ST_MALFORMED;
        res[0]           = sum;
        n                = 2'd1;
        done_nxt         = 1'b1;
      end else if (pos_r == '0 && rec_limit == 8'd0) begin
        sum.record_count = recs_r;
        sum.status       = ndefp_pkg::ST_BAD_PARAM;
        res[0]           = sum;
        n                = 2'd1;
        done_nxt         = 1'b1;
      end else begin
        unique case (phase_r)
          PH_HDR: begin
            if (first_r && (beat.data_byte & ndefp_pkg::FLAG_MB) == 8'd0) begin
              sum.record_count = recs_r;
              sum.status       = ndefp_pkg::ST_MALFORMED;
              res[0]           = sum;
              n                = 2'd1;
              done_nxt         = 1'b1;
            end else begin
              first_nxt = 1'b0;
              flags_nxt = beat.data_byte;
              phase_nxt = PH_TLEN;
            end
          end
          PH_TLEN: begin
            tlen_nxt  = beat.data_byte;
            idlen_nxt = 8'd0;
            rem_nxt   = 32'd0;
            lbi_nxt   = 2'd0;
            phase_nxt = PH_PLEN;
          end
          PH_PLEN: begin
            rem_nxt = {rem_r[23:0], beat.data_byte};
            if ((flags_r & ndefp_pkg::FLAG_SR) != 8'd0 || lbi_r == 2'd3) begin
              lbi_nxt = 2'd0;
              if ((flags_r & ndefp_pkg::FLAG_IL) != 8'd0) begin
                phase_nxt = PH_IDLEN;
              end else begin
                go_bodies = 1'b1;
              end
            end else begin
              lbi_nxt = lbi_r + 2'd1;
            end
          end
          PH_IDLEN: begin
            idlen_nxt = beat.data_byte;
            go_bodies = 1'b1;
          end
          PH_TYPE: begin
            if ((next_pos - fo0_r) >= {{(ndefp_pkg::POS_BITS-8){1'b0}}, tlen_r}) begin
              go_id = 1'b1;
            end
          end
          PH_ID: begin
            if ((next_pos - fo1_r) >= {{(ndefp_pkg::POS_BITS-8){1'b0}}, idlen_r}) begin
              go_pay = 1'b1;
            end
          end
          default: begin
            if (rem_r != 32'd0) begin
              rem_nxt = rem_r - 32'd1;
            end
            if (rem_nxt == 32'd0) begin
              completed = 1'b1;
            end
          end
        endcase

        if (go_bodies) begin
          fo0_nxt = next_pos;
          if (tlen_nxt != 8'd0) begin
            phase_nxt = PH_TYPE;
          end else begin
            go_id = 1'b1;
          end
        end
        if (go_id) begin
          if (idlen_nxt != 8'd0) begin
            fo1_nxt   = next_pos;
            phase_nxt = PH_ID;
          end else begin
            fo1_nxt = '0;
            go_pay  = 1'b1;
          end
        end
        if (go_pay) begin
          fo2_nxt = next_pos;
          if (rem_nxt != 32'd0) begin
            phase_nxt = PH_PAY;
          end else begin
            completed = 1'b1;
          end
        end

        pos_nxt = next_pos;

        if (completed) begin
          recs_nxt              = recs_r + 8'd1;
          res[0].item_kind      = ndefp_pkg::KIND_RECORD;
          res[0].tnf            = flags_nxt[2:0] & ndefp_pkg::MASK_TNF[2:0];
          res[0].type_offset    = fo0_nxt;
          res[0].type_length    = tlen_nxt;
          res[0].id_offset      = fo1_nxt;
          res[0].id_length      = idlen_nxt;
          res[0].payload_offset = fo2_nxt;
          res[0].payload_length = 16'(next_pos - fo2_nxt);
          res[0].record_count   = recs_nxt;
          res[0].status         = ndefp_pkg::ST_OK;
          n                     = 2'd1;
          phase_nxt             = PH_HDR;
          if ((flags_nxt & ndefp_pkg::FLAG_ME) != 8'd0 || recs_nxt >= rec_limit) begin
            sum.record_count = recs_nxt;
            sum.status       = ndefp_pkg::ST_OK;
            res[1]           = sum;
            n                = 2'd2;
            done_nxt         = 1'b1;
          end
        end
      end

      if (beat.end_of_buffer && !done_nxt) begin
        if (phase_nxt != PH_HDR) begin
          eob_st = ndefp_pkg::ST_MALFORMED;
        end else if (recs_nxt == 8'd0) begin
          eob_st = ndefp_pkg::ST_NO_RECORD;
        end else begin
          eob_st = ndefp_pkg::ST_OK;
        end
        sum.record_count = recs_nxt;
        sum.status       = eob_st;
        res[n[0]]        = sum;
        n                = n + 2'd1;
      end
    end

    if (n == 2'd1) begin
      res[0].last_of_run = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last_of_run = 1'b1;
    end

    if (beat_acc && beat.end_of_buffer) begin
      phase_nxt = PH_HDR;
      pos_nxt   = '0;
      flags_nxt = 8'd0;
      lbi_nxt   = 2'd0;
      rem_nxt   = 32'd0;
      tlen_nxt  = 8'd0;
      idlen_nxt = 8'd0;
      fo0_nxt   = '0;
      fo1_nxt   = '0;
      fo2_nxt   = '0;
      recs_nxt  = 8'd0;
      first_nxt = 1'b1;
      done_nxt  = 1'b0;
    end
  end

  assign res0    = res[0];
  assign res1    = res[1];
  assign res_cnt = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      pos_r   <= '0;
      flags_r <= 8'd0;
      lbi_r   <= 2'd0;
      rem_r   <= 32'd0;
      tlen_r  <= 8'd0;
      idlen_r <= 8'd0;
      fo0_r   <= '0;
      fo1_r   <= '0;
      fo2_r   <= '0;
      recs_r  <= 8'd0;
      first_r <= 1'b1;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      flags_r <= flags_nxt;
      lbi_r   <= lbi_nxt;
      rem_r   <= rem_nxt;
      tlen_r  <= tlen_nxt;
      idlen_r <= idlen_nxt;
      fo0_r   <= fo0_nxt;
      fo1_r   <= fo1_nxt;
      fo2_r   <= fo2_nxt;
      recs_r  <= recs_nxt;
      first_r <= first_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

[design/ndefp_queue.sv]
module ndefp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_cnt,
  input  ndefp_pkg::out_t d0,
  input  ndefp_pkg::out_t d1,
  input  logic            pop,
  output logic            q_valid,
  output ndefp_pkg::out_t q,
  output logic            low_room
);

  ndefp_pkg::out_t                  mem_r [ndefp_pkg::QUEUE_DEPTH];
  logic [ndefp_pkg::QPTR_BITS-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt, wptr_p1;
  logic [ndefp_pkg::QCNT_BITS-1:0]  cnt_r, cnt_nxt;

  assign wptr_p1  = wptr_r + 1'b1;
  assign q_valid  = cnt_r != '0;
  assign q        = mem_r[rptr_r];
  assign low_room = cnt_r > ndefp_pkg::QCNT_BITS'(ndefp_pkg::QUEUE_DEPTH - 2);

  always_comb begin
    wptr_nxt = wptr_r + ndefp_pkg::QPTR_BITS'(push_cnt);
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + ndefp_pkg::QCNT_BITS'(push_cnt)
             - ndefp_pkg::QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wptr_r] <= d0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wptr_p1] <= d1;
    end
  end

endmodule

[design/ndef_record_parser.sv]
// NDEF record parser: takes one message byte per cycle on the in_ channel and returns record
// descriptors and a final message summary on the out_ channel. Every byte is decoded in the
// cycle it is accepted; results go into a four-entry result queue, and in_stall rises while
// fewer than two queue slots are free. A byte yields at most two results (a descriptor and the
// summary), so with the output draining the block sustains one byte per clock, and a byte that
// ends a record and the message queues the descriptor, then the summary. The record limit sits
// at byte address 0 of the APB port and should only be written while no byte is in flight.
module ndef_record_parser (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ndefp_pkg::in_t                       in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ndefp_pkg::out_t                      out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ndefp_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [7:0]      rec_limit_r;
  logic            in_acc;
  logic            out_pop;
  ndefp_pkg::out_t res0, res1;
  logic [1:0]      res_cnt;

  assign pready  = 1'b1;
  assign prdata  = (paddr == ndefp_pkg::REG_REC_LIMIT) ? {24'd0, rec_limit_r} : 32'd0;
  assign in_acc  = in_valid && !in_stall;
  assign out_pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_limit_r <= ndefp_pkg::REC_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == ndefp_pkg::REG_REC_LIMIT) begin
      rec_limit_r <= pwdata[7:0];
    end
  end

  ndefp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_acc  (in_acc),
    .beat      (in_data),
    .rec_limit (rec_limit_r),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  ndefp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (res_cnt),
    .d0       (res0),
    .d1       (res1),
    .pop      (out_pop),
    .q_valid  (out_valid),
    .q        (out_data),
    .low_room (in_stall)
  );

endmodule

[design/ndefp_chk.sv]
module ndefp_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input ndefp_pkg::out_t                     out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_desc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == ndefp_pkg::KIND_RECORD |->
      out_data.status == ndefp_pkg::ST_OK && out_data.record_count != 8'd0)
    else $error("descriptor with status or zero count");

  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == ndefp_pkg::KIND_SUMMARY |->
      out_data.last_of_run && out_data.tnf == 3'd0 && out_data.type_length == 8'd0 &&
      out_data.payload_length == 16'd0 && out_data.payload_offset == '0)
    else $error("summary beat carries record fields");

endmodule

bind ndef_record_parser ndefp_chk u_chk (.*);
